// ===== src/ncbc_pkg.sv =====
// ----------------------------------------------------------------------------
// ncbc_pkg: shared types, codes and helpers for the normal cone cull unit
// Holds the verdict codes, configuration register indexes, the stage
// records that move between modules, and one square root recurrence step.
// ----------------------------------------------------------------------------
package ncbc_pkg;

  // Verdict codes carried on the result item.
  localparam logic [1:0] VERDICT_REJECT  = 2'd0;
  localparam logic [1:0] VERDICT_NO_CONE = 2'd1;
  localparam logic [1:0] VERDICT_INSIDE  = 2'd2;
  localparam logic [1:0] VERDICT_KEPT    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VIEWER_X = 2'd0;
  localparam logic [1:0] CFG_VIEWER_Y = 2'd1;
  localparam logic [1:0] CFG_VIEWER_Z = 2'd2;

  // Square root pipeline geometry: a 72-bit radicand gives a 36-bit root.
  localparam int SQ_STAGES = 36;
  localparam int LANES     = 3;
  localparam int LANE_T    = 0;  // squared view distance (doubled units)
  localparam int LANE_D    = 1;  // squared half-diagonal (doubled units)
  localparam int LANE_S    = 2;  // one minus cosine squared, Q4.28

  // Registered differences after the first stage.
  typedef struct packed {
    logic [34:0] tx;
    logic [34:0] ty;
    logic [34:0] tz;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] dz;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [15:0] cc;
    logic        cone;
  } diff_t;

  // Registered products after the second stage.
  typedef struct packed {
    logic [69:0] tsx;
    logic [69:0] tsy;
    logic [69:0] tsz;
    logic [65:0] dsx;
    logic [65:0] dsy;
    logic [65:0] dsz;
    logic [50:0] px;
    logic [50:0] py;
    logic [50:0] pz;
    logic [28:0] csq;
    logic        cone;
  } prod_t;

  // Radicands and dot product handed to the square root pipeline.
  typedef struct packed {
    logic [71:0] t2;
    logic [71:0] d2;
    logic [71:0] rad;
    logic [52:0] p;
    logic        cone;
  } sqin_t;

  // Data that rides beside the square root lanes.
  typedef struct packed {
    logic [52:0] p;
    logic [1:0]  verdict;
  } side_t;

  // State of one square root lane.
  typedef struct packed {
    logic [71:0] rad;
    logic [37:0] rem;
    logic [35:0] root;
  } sq_lane_t;

  // One restoring square root step: brings down two radicand bits and
  // decides one root bit.
  function automatic sq_lane_t sq_step(input sq_lane_t a);
    sq_lane_t    res;
    logic [37:0] r;
    logic [37:0] trial;
    r     = {a.rem[35:0], a.rad[71:70]};
    trial = {a.root, 2'b01};
    res.rad = {a.rad[69:0], 2'b00};
    if (r >= trial) begin
      res.rem  = r - trial;
      res.root = {a.root[34:0], 1'b1};
    end else begin
      res.rem  = r;
      res.root = {a.root[34:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// ===== src/normal_cone_backface_cull_unit.sv =====
// ----------------------------------------------------------------------------
// normal_cone_backface_cull_unit: normal cone back-face cull
// Takes one box with its normal cone per item and returns one verdict.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one box and cone per item; tuser holds the cone
//   valid flag. The master stream returns one result per item, in order:
//   tdata holds the verdict, tuser the rejected flag.
//   The configuration channel writes the viewer position (index 0 to 2 for
//   x, y, z); it is always ready. Writes are to be made while the block
//   idles; the block itself does not enforce this. There are three front-end
//   stages, a 36-stage square root pipeline that decides one root bit per
//   stage, a multiply stage and the output register. All stages advance
//   together, one item per clock, while the output register is empty or
//   being taken; when the receiver stalls with a result held, the whole
//   pipeline freezes and s_tready drops, so nothing is lost or repeated.
//   Synchronous reset empties the pipeline and sets the viewer to the origin.
// ----------------------------------------------------------------------------
module normal_cone_backface_cull_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // axis_x, axis_y, axis_z, aperture_cosine
  input  logic [255:0] s_tdata,
  // cone_valid
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // verdict, zero fill
  output logic [7:0]   m_tdata,
  // rejected
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0]     viewer_x;
  logic [31:0]     viewer_y;
  logic [31:0]     viewer_z;
  logic            en;
  logic            front_valid;
  ncbc_pkg::sqin_t front_data;
  logic            sq_valid;
  logic [35:0]     root_t;
  logic [35:0]     root_d;
  logic [35:0]     root_s;
  ncbc_pkg::side_t sq_side;
  logic [1:0]      verdict;

  // Global advance.
  assign en       = m_tready | ~m_tvalid;
  assign s_tready = en;

  // Viewer registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      viewer_x <= '0;
      viewer_y <= '0;
      viewer_z <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ncbc_pkg::CFG_VIEWER_X: viewer_x <= cfg_data;
        ncbc_pkg::CFG_VIEWER_Y: viewer_y <= cfg_data;
        ncbc_pkg::CFG_VIEWER_Z: viewer_z <= cfg_data;
        default: ;
      endcase
    end
  end

  ncbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .in_cone   (s_tuser),
    .viewer_x  (viewer_x),
    .viewer_y  (viewer_y),
    .viewer_z  (viewer_z),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  ncbc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (sq_valid),
    .root_t    (root_t),
    .root_d    (root_d),
    .root_s    (root_s),
    .out_side  (sq_side)
  );

  ncbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .root_t    (root_t),
    .root_d    (root_d),
    .root_s    (root_s),
    .in_side   (sq_side),
    .out_valid (m_tvalid),
    .rejected  (m_tuser),
    .verdict   (verdict)
  );

  assign m_tdata = {6'b0, verdict};

endmodule

// ===== src/ncbc_front.sv =====
// ----------------------------------------------------------------------------
// ncbc_front: geometry front end
// Three register stages: differences, products, then sums of squares,
// the dot product and the aperture sine radicand.
// ----------------------------------------------------------------------------
module ncbc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [255:0]         in_data,
  input  logic                 in_cone,
  input  logic [31:0]          viewer_x,
  input  logic [31:0]          viewer_y,
  input  logic [31:0]          viewer_z,
  output logic                 out_valid,
  output ncbc_pkg::sqin_t      out_data
);

  ncbc_pkg::diff_t st1;
  ncbc_pkg::prod_t st2;
  logic            v1;
  logic            v2;

  logic signed [31:0] mnx, mny, mnz, mxx, mxy, mxz;
  logic signed [15:0] cin;
  logic signed [15:0] cclamp;

  assign mnx = in_data[31:0];
  assign mny = in_data[63:32];
  assign mnz = in_data[95:64];
  assign mxx = in_data[127:96];
  assign mxy = in_data[159:128];
  assign mxz = in_data[191:160];
  assign cin = in_data[255:240];

  // Clamp the cosine to plus or minus one in Q2.14.
  always_comb begin
    if (cin < -16'sd16384) begin
      cclamp = -16'sd16384;
    end else if (cin > 16'sd16384) begin
      cclamp = 16'sd16384;
    end else begin
      cclamp = cin;
    end
  end

  // Stage one: doubled center minus doubled viewer, and box extent (max minus min).
  always_ff @(posedge clk) begin
    if (en) begin
      st1.tx   <= 35'($signed(mnx) + $signed(mxx)) - {{2{viewer_x[31]}}, viewer_x, 1'b0};
      st1.ty   <= 35'($signed(mny) + $signed(mxy)) - {{2{viewer_y[31]}}, viewer_y, 1'b0};
      st1.tz   <= 35'($signed(mnz) + $signed(mxz)) - {{2{viewer_z[31]}}, viewer_z, 1'b0};
      st1.dx   <= 33'($signed(mxx) - $signed(mnx));
      st1.dy   <= 33'($signed(mxy) - $signed(mny));
      st1.dz   <= 33'($signed(mxz) - $signed(mnz));
      st1.ax   <= in_data[207:192];
      st1.ay   <= in_data[223:208];
      st1.az   <= in_data[239:224];
      st1.cc   <= cclamp;
      st1.cone <= in_cone;
    end
  end

  // Products of stage two.
  logic signed [69:0] tsx, tsy, tsz;
  logic signed [65:0] dsx, dsy, dsz;
  logic signed [50:0] px, py, pz;
  logic signed [31:0] csq;

  assign tsx = $signed(st1.tx) * $signed(st1.tx);
  assign tsy = $signed(st1.ty) * $signed(st1.ty);
  assign tsz = $signed(st1.tz) * $signed(st1.tz);
  assign dsx = $signed(st1.dx) * $signed(st1.dx);
  assign dsy = $signed(st1.dy) * $signed(st1.dy);
  assign dsz = $signed(st1.dz) * $signed(st1.dz);
  assign px  = $signed(st1.tx) * $signed(st1.ax);
  assign py  = $signed(st1.ty) * $signed(st1.ay);
  assign pz  = $signed(st1.tz) * $signed(st1.az);
  assign csq = $signed(st1.cc) * $signed(st1.cc);

  always_ff @(posedge clk) begin
    if (en) begin
      st2.tsx  <= tsx;
      st2.tsy  <= tsy;
      st2.tsz  <= tsz;
      st2.dsx  <= dsx;
      st2.dsy  <= dsy;
      st2.dsz  <= dsz;
      st2.px   <= px;
      st2.py   <= py;
      st2.pz   <= pz;
      st2.csq  <= csq[28:0];
      st2.cone <= st1.cone;
    end
  end

  // Stage three: sums of squares, dot product and sine radicand.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.t2   <= {2'b0, st2.tsx} + {2'b0, st2.tsy} + {2'b0, st2.tsz};
      out_data.d2   <= {6'b0, st2.dsx} + {6'b0, st2.dsy} + {6'b0, st2.dsz};
      out_data.rad  <= {43'b0, 29'h1000_0000 - st2.csq};
      out_data.p    <= 53'($signed(st2.px)) + 53'($signed(st2.py))
                     + 53'($signed(st2.pz));
      out_data.cone <= st2.cone;
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ===== src/ncbc_sqrt.sv =====
// ----------------------------------------------------------------------------
// ncbc_sqrt: pipelined floor square root, three lanes
// One root bit per stage over 36 stages. The inside-sphere decision is
// made on entry and rides along with the dot product.
// ----------------------------------------------------------------------------
module ncbc_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  ncbc_pkg::sqin_t      in_data,
  output logic                 out_valid,
  output logic [35:0]          root_t,
  output logic [35:0]          root_d,
  output logic [35:0]          root_s,
  output ncbc_pkg::side_t      out_side
);

  ncbc_pkg::sq_lane_t lane [0:ncbc_pkg::SQ_STAGES-1][0:ncbc_pkg::LANES-1];
  ncbc_pkg::side_t    side [0:ncbc_pkg::SQ_STAGES-1];
  logic               vld  [0:ncbc_pkg::SQ_STAGES-1];

  ncbc_pkg::sq_lane_t init [0:ncbc_pkg::LANES-1];
  ncbc_pkg::side_t    side_in;

  // Lane start values.
  always_comb begin
    init[ncbc_pkg::LANE_T] = '{rad: in_data.t2,  rem: '0, root: '0};
    init[ncbc_pkg::LANE_D] = '{rad: in_data.d2,  rem: '0, root: '0};
    init[ncbc_pkg::LANE_S] = '{rad: in_data.rad, rem: '0, root: '0};
  end

  // Verdict before the facing test.
  always_comb begin
    side_in.p = in_data.p;
    if (!in_data.cone) begin
      side_in.verdict = ncbc_pkg::VERDICT_NO_CONE;
    end else if (in_data.t2 <= in_data.d2) begin
      side_in.verdict = ncbc_pkg::VERDICT_INSIDE;
    end else begin
      side_in.verdict = ncbc_pkg::VERDICT_KEPT;
    end
  end

  // First stage.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ncbc_pkg::LANES; i++) begin
        lane[0][i] <= ncbc_pkg::sq_step(init[i]);
      end
      side[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // Remaining stages.
  for (genvar k = 1; k < ncbc_pkg::SQ_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < ncbc_pkg::LANES; i++) begin
          lane[k][i] <= ncbc_pkg::sq_step(lane[k-1][i]);
        end
        side[k] <= side[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign out_valid = vld[ncbc_pkg::SQ_STAGES-1];
  assign root_t    = lane[ncbc_pkg::SQ_STAGES-1][ncbc_pkg::LANE_T].root;
  assign root_d    = lane[ncbc_pkg::SQ_STAGES-1][ncbc_pkg::LANE_D].root;
  assign root_s    = lane[ncbc_pkg::SQ_STAGES-1][ncbc_pkg::LANE_S].root;
  assign out_side  = side[ncbc_pkg::SQ_STAGES-1];

endmodule

// ===== src/ncbc_back.sv =====
// ----------------------------------------------------------------------------
// ncbc_back: facing test and output register
// Scales the view distance by the aperture sine, adds the sphere term,
// and compares against the dot product.
// ----------------------------------------------------------------------------
module ncbc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [35:0]          root_t,
  input  logic [35:0]          root_d,
  input  logic [35:0]          root_s,
  input  ncbc_pkg::side_t      in_side,
  output logic                 out_valid,
  output logic                 rejected,
  output logic [1:0]           verdict
);

  logic            vm;
  logic [50:0]     prod;
  logic [47:0]     ldsh;
  ncbc_pkg::side_t sm;
  logic [51:0]     rhs;
  logic            face_away;

  // Multiply stage: sine times distance, sphere term as a shift.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= root_s[14:0] * root_t;
      ldsh <= {root_d[33:0], 14'b0};
      sm   <= in_side;
    end
  end

  assign rhs       = {1'b0, prod} + {4'b0, ldsh};
  assign face_away = $signed(sm.p) > $signed({1'b0, rhs});

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (sm.verdict == ncbc_pkg::VERDICT_KEPT && face_away) begin
        verdict  <= ncbc_pkg::VERDICT_REJECT;
        rejected <= 1'b1;
      end else begin
        verdict  <= sm.verdict;
        rejected <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vm        <= in_valid;
      out_valid <= vm;
    end
  end

endmodule
